>>> rtl/multi_channel_tick_accumulator_core_assert.svh
// Assertion macros for the tick accumulator core
`ifndef MULTI_CHANNEL_TICK_ACCUMULATOR_CORE_ASSERT_SVH
`define MULTI_CHANNEL_TICK_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define MCTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcta assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define MCTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcta assertion failed");

`endif

>>> rtl/mcta_pkg.sv
// Types, constants and helpers shared by the tick accumulator core
package mcta_pkg;

  typedef enum logic [2:0] {
    REQ_UPDATE  = 3'd0,
    REQ_CREATE  = 3'd1,
    REQ_DELETE  = 3'd2,
    REQ_PAUSE   = 3'd3,
    REQ_UNPAUSE = 3'd4,
    REQ_RESYNC  = 3'd5,
    REQ_READ    = 3'd6,
    REQ_FIND    = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_INACTIVE    = 2'd1,
    STAT_NOT_FOUND   = 2'd2,
    STAT_ZERO_PERIOD = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_GSEL, S_RD, S_MUL, S_SUM, S_DIV, S_SD, S_WB,
    S_SRD, S_SDAT, S_FRD, S_FDAT, S_OUT
  } state_e;

  localparam logic [1:0] MOD_FIXED = 2'd1;
  localparam logic [1:0] MOD_MUL   = 2'd2;
  localparam logic [5:0] DIV_LAST  = 6'd32;

  typedef struct packed {
    logic [31:0] period;
    logic [2:0]  kind;
    logic [1:0]  mod_mode;
    logic [31:0] mod_factor;
    logic [31:0] tick_count;
    logic [31:0] remainder;
    logic [31:0] clock_time;
    logic [31:0] stable_delta;
  } entry_t;

  typedef struct packed {
    logic [3:0]  slot;
    status_e     status;
    logic        tick_event;
    logic [31:0] ticks_gained;
    logic [31:0] tick_count;
    logic [31:0] remainder;
    logic [31:0] clock_time;
    logic [31:0] stable_delta;
    logic        is_last;
  } result_t;

  function automatic logic [31:0] scale_sel(logic [1:0] mode, logic [31:0] factor,
                                            logic [31:0] dt, logic [63:0] prod);
    logic [31:0] r;
    case (mode)
      MOD_FIXED: r = {16'd0, factor[31:16]};
      MOD_MUL:   r = (|prod[63:48]) ? '1 : prod[47:16];
      default:   r = dt;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/mcta_ram.sv
// Generic single-port-write, registered-read RAM
module mcta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/multi_channel_tick_accumulator_core.sv
// Tick accumulator core: clock table in RAM, request sequencer, APB registers
// An update scans the slots in order, skipping inactive or paused ones; each
// running slot gets a RAM read, modifier multiply, add, a 33-step restoring
// divider at one quotient bit a cycle, stable-delta multiply and write-back, and a
// word is handed on for each slot that gained ticks. Find reads only the active
// slots it searches. One request is worked on at a time, and the next is taken
// while a finished word still waits at the output.
module multi_channel_tick_accumulator_core
  import mcta_pkg::*;
#(
  parameter int NUM_CLOCKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  clock_index_i,
  input  logic [31:0] now_time_i,
  input  logic [31:0] tick_period_i,
  input  logic [2:0]  clock_kind_in_i,
  input  logic [1:0]  mod_mode_in_i,
  input  logic [31:0] mod_factor_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  result_clock_o,
  output logic [1:0]  status_o,
  output logic        tick_event_o,
  output logic [31:0] ticks_gained_o,
  output logic [31:0] tick_count_out_o,
  output logic [31:0] remainder_out_o,
  output logic [31:0] clock_time_out_o,
  output logic [31:0] stable_delta_out_o,
  output logic        is_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SW = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
  localparam int CW = $clog2(NUM_CLOCKS + 1);
  localparam logic [CW-1:0] LAST_SLOT = CW'(NUM_CLOCKS);

  state_e state_q, state_d;
  req_e        req_q;
  logic [3:0]  idx_q;
  logic [31:0] now_q, per_q, mfac_q;
  logic [2:0]  kind_q;
  logic [1:0]  mmode_q;
  logic [31:0] last_time_q;
  logic [1:0]  gmode_q;
  logic [31:0] gfactor_q;
  logic [NUM_CLOCKS-1:0] active_q, paused_q;
  logic [63:0] prod_q;
  logic [31:0] dt_q, gdt_q, cdt_q, sd_q;
  logic [CW-1:0] slot_q;
  logic [32:0] div_r_q, div_q_q;
  logic [5:0]  div_cnt_q;
  result_t     res_q, out_q;
  logic        cont_q, out_valid_q;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd;
  logic [SW-1:0] idx_addr, slot_addr;
  logic          idx_in_range, act, slot_run, out_free, ticks_nz;
  logic [33:0]   div_t;
  logic          div_ge;
  logic [31:0]   cdt;
  logic [32:0]   sum;
  entry_t        wb_entry, new_entry;

  mcta_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_CLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  function automatic result_t make_res(logic [3:0] slot, status_e st, logic ev,
                                       logic [31:0] gained, logic show, entry_t e);
    result_t r;
    r.slot         = slot;
    r.status       = st;
    r.tick_event   = ev;
    r.ticks_gained = gained;
    r.tick_count   = show ? e.tick_count : '0;
    r.remainder    = show ? e.remainder : '0;
    r.clock_time   = show ? e.clock_time : '0;
    r.stable_delta = show ? e.stable_delta : '0;
    r.is_last      = ~ev;
    return r;
  endfunction

  assign idx_addr     = SW'(idx_q);
  assign slot_addr    = slot_q[SW-1:0];
  assign idx_in_range = {28'd0, idx_q} < 32'(NUM_CLOCKS);
  assign act          = idx_in_range && active_q[idx_addr];
  assign slot_run     = active_q[slot_addr] && !paused_q[slot_addr];
  assign out_free     = !out_valid_q || out_ready_i;
  assign ticks_nz     = |div_q_q;
  assign div_t        = {div_r_q, div_q_q[32]};
  assign div_ge       = div_t >= {2'b00, rd.period};
  assign cdt          = scale_sel(rd.mod_mode, rd.mod_factor, gdt_q, prod_q);
  assign sum          = {1'b0, cdt} + {1'b0, rd.remainder};

  always_comb begin
    wb_entry              = rd;
    wb_entry.tick_count   = rd.tick_count + div_q_q[31:0];
    wb_entry.remainder    = div_r_q[31:0];
    wb_entry.clock_time   = rd.clock_time + cdt_q;
    wb_entry.stable_delta = ticks_nz ? sd_q : rd.stable_delta;
  end

  always_comb begin
    new_entry            = '0;
    new_entry.period     = per_q;
    new_entry.kind       = kind_q;
    new_entry.mod_mode   = mmode_q;
    new_entry.mod_factor = mfac_q;
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = idx_addr;
    ram_raddr  = slot_addr;
    ram_wdata  = new_entry;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        unique case (req_q)
          REQ_UPDATE: state_d = S_GSEL;
          REQ_RESYNC: state_d = S_OUT;
          REQ_FIND:   state_d = idx_in_range ? S_FRD : S_OUT;
          default:    state_d = S_SRD;
        endcase
      end
      S_GSEL: state_d = S_RD;
      S_RD: begin
        if (slot_q == LAST_SLOT) begin
          state_d = S_OUT;
        end else if (slot_run) begin
          ram_re  = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = (rd.period == '0) ? S_SD : S_DIV;
      S_DIV: if (div_cnt_q == DIV_LAST) state_d = S_SD;
      S_SD:  state_d = S_WB;
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr;
        ram_wdata = wb_entry;
        state_d   = ticks_nz ? S_OUT : S_RD;
      end
      S_SRD: begin
        ram_re    = idx_in_range;
        ram_raddr = idx_addr;
        state_d   = S_SDAT;
      end
      S_SDAT: begin
        ram_we  = (req_q == REQ_CREATE) && idx_in_range && !act && (per_q != '0);
        state_d = S_OUT;
      end
      S_FRD: begin
        if (slot_q == LAST_SLOT) begin
          state_d = S_OUT;
        end else if (active_q[slot_addr]) begin
          ram_re  = 1'b1;
          state_d = S_FDAT;
        end
      end
      S_FDAT: state_d = (rd.period == per_q && rd.kind == kind_q) ? S_OUT : S_FRD;
      S_OUT:  if (out_free) state_d = cont_q ? S_RD : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      active_q    <= '0;
      paused_q    <= '0;
      out_valid_q <= 1'b0;
      cont_q      <= 1'b0;
      slot_q      <= '0;
      div_cnt_q   <= '0;
    end else begin
      if (out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_DISP: begin
          cont_q <= 1'b0;
          slot_q <= CW'(idx_q);
          if (req_q == REQ_RESYNC) last_time_q <= now_q;
        end
        S_GSEL: slot_q <= '0;
        S_RD: begin
          if (slot_q == LAST_SLOT) begin
            last_time_q <= now_q;
            cont_q      <= 1'b0;
          end else if (!slot_run) begin
            slot_q <= slot_q + 1'b1;
          end
        end
        S_SUM: div_cnt_q <= '0;
        S_DIV: div_cnt_q <= div_cnt_q + 1'b1;
        S_WB: begin
          slot_q <= slot_q + 1'b1;
          cont_q <= 1'b1;
        end
        S_SDAT: begin
          if (act) begin
            case (req_q)
              REQ_DELETE: begin
                active_q[idx_addr] <= 1'b0;
                paused_q[idx_addr] <= 1'b0;
              end
              REQ_PAUSE:   paused_q[idx_addr] <= 1'b1;
              REQ_UNPAUSE: paused_q[idx_addr] <= 1'b0;
              default: ;
            endcase
          end else if (req_q == REQ_CREATE && idx_in_range && per_q != '0) begin
            active_q[idx_addr] <= 1'b1;
            paused_q[idx_addr] <= 1'b0;
          end
        end
        S_FRD: if (slot_q != LAST_SLOT && !active_q[slot_addr]) slot_q <= slot_q + 1'b1;
        S_FDAT: if (!(rd.period == per_q && rd.kind == kind_q)) slot_q <= slot_q + 1'b1;
        S_OUT: if (out_free) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q   <= req_e'(req_type_i);
      idx_q   <= clock_index_i;
      now_q   <= now_time_i;
      per_q   <= tick_period_i;
      kind_q  <= clock_kind_in_i;
      mmode_q <= mod_mode_in_i;
      mfac_q  <= mod_factor_in_i;
    end
    if (state_q == S_OUT && out_free) out_q <= res_q;
    case (state_q)
      S_DISP: begin
        dt_q   <= now_q - last_time_q;
        prod_q <= {32'd0, gfactor_q} * {32'd0, now_q - last_time_q};
        if (req_q == REQ_RESYNC) begin
          res_q <= make_res(4'd0, STAT_OK, 1'b0, '0, 1'b0, rd);
        end else if (req_q == REQ_FIND) begin
          res_q <= make_res(4'd0, STAT_NOT_FOUND, 1'b0, '0, 1'b0, rd);
        end
      end
      S_GSEL: gdt_q <= scale_sel(gmode_q, gfactor_q, dt_q, prod_q);
      S_RD: if (slot_q == LAST_SLOT) res_q <= make_res(4'd0, STAT_OK, 1'b0, '0, 1'b0, rd);
      S_MUL: prod_q <= {32'd0, rd.mod_factor} * {32'd0, gdt_q};
      S_SUM: begin
        cdt_q <= cdt;
        if (rd.period == '0) begin
          div_r_q <= sum;
          div_q_q <= '0;
        end else begin
          div_r_q <= '0;
          div_q_q <= sum;
        end
      end
      S_DIV: begin
        div_r_q <= div_ge ? 33'(div_t - {2'b00, rd.period}) : div_t[32:0];
        div_q_q <= {div_q_q[31:0], div_ge};
      end
      S_SD: sd_q <= 32'(div_q_q[31:0] * rd.period);
      S_WB: res_q <= make_res(4'(slot_q), STAT_OK, 1'b1,
                              div_q_q[32] ? '1 : div_q_q[31:0], 1'b1, wb_entry);
      S_SDAT: begin
        unique case (req_q)
          REQ_CREATE: begin
            if (!idx_in_range || act) begin
              res_q <= make_res(idx_q, STAT_INACTIVE, 1'b0, '0, act, rd);
            end else if (per_q == '0) begin
              res_q <= make_res(idx_q, STAT_ZERO_PERIOD, 1'b0, '0, 1'b0, rd);
            end else begin
              res_q <= make_res(idx_q, STAT_OK, 1'b0, '0, 1'b1, new_entry);
            end
          end
          REQ_DELETE:
            res_q <= make_res(idx_q, act ? STAT_OK : STAT_INACTIVE, 1'b0, '0, 1'b0, rd);
          default:
            res_q <= make_res(idx_q, act ? STAT_OK : STAT_INACTIVE, 1'b0, '0, act, rd);
        endcase
      end
      S_FRD: if (slot_q == LAST_SLOT) begin
        res_q <= make_res(4'd0, STAT_NOT_FOUND, 1'b0, '0, 1'b0, rd);
      end
      S_FDAT: res_q <= make_res(4'(slot_q), STAT_OK, 1'b0, '0, 1'b1, rd);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gmode_q   <= '0;
      gfactor_q <= 32'h0001_0000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        gfactor_q <= pwdata;
      end else begin
        gmode_q <= pwdata[1:0];
      end
    end
  end

  assign prdata = paddr[2] ? gfactor_q : {30'd0, gmode_q};
  assign pready = 1'b1;

  assign out_valid_o        = out_valid_q;
  assign result_clock_o     = out_q.slot;
  assign status_o           = out_q.status;
  assign tick_event_o       = out_q.tick_event;
  assign ticks_gained_o     = out_q.ticks_gained;
  assign tick_count_out_o   = out_q.tick_count;
  assign remainder_out_o    = out_q.remainder;
  assign clock_time_out_o   = out_q.clock_time;
  assign stable_delta_out_o = out_q.stable_delta;
  assign is_last_o          = out_q.is_last;

`include "multi_channel_tick_accumulator_core_assert.svh"

  `MCTA_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q == S_DISP)
  `MCTA_ASSERT_IMP(a_paused_only_active, 1'b1, (paused_q & ~active_q) == '0)
  `MCTA_ASSERT_IMP(a_ram_write_states, ram_we, state_q == S_WB || state_q == S_SDAT)
  `MCTA_ASSERT_IMP(a_div_count_bound, state_q == S_DIV, div_cnt_q <= DIV_LAST)
endmodule
